### src/chet_pkg.sv
// Shared constants, types and the arctangent table of the compass heading error tracker.
package chet_pkg;

  // Angle resolution and CORDIC length.
  localparam int ANGLE_FRACTION_BITS = 7;
  localparam int CORDIC_ITERATIONS   = 16;
  localparam int GUARD_BITS          = 12;
  localparam int WORK_BITS           = ANGLE_FRACTION_BITS + GUARD_BITS;
  localparam int TABLE_BITS          = 22;
  localparam int TABLE_LEN           = 24;
  localparam int ITER_N = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS : TABLE_LEN;
  localparam int IDX_W               = $clog2(TABLE_LEN);
  localparam int ATAN_SHIFT          = TABLE_BITS - WORK_BITS;
  localparam int ATAN_HALF           = (ATAN_SHIFT > 0) ? (1 << (ATAN_SHIFT - 1)) : 0;

  // Field and datapath widths.
  localparam int MAG_W      = 16;
  localparam int HEAD_W     = 16;
  localparam int ERR_W      = 16;
  localparam int CUM_W      = 32;
  localparam int THR_W      = 31;
  localparam int SUM_W      = 18;
  localparam int DIV_W      = 18;
  localparam int XY_W       = 27;
  localparam int Z_W        = WORK_BITS + 10;
  localparam int HR_W       = Z_W - GUARD_BITS;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 88;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  // Angles in output units.
  localparam int H_QUARTER = 90 << ANGLE_FRACTION_BITS;
  localparam int H_HALF    = 180 << ANGLE_FRACTION_BITS;
  localparam int H_FULL    = 360 << ANGLE_FRACTION_BITS;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_TURN  = 2'd0;
  localparam logic [1:0] REG_ALARM = 2'd1;
  localparam logic [1:0] REG_HUGE  = 2'd2;

  // Reset values of the thresholds.
  localparam logic [THR_W-1:0] TURN_RESET  = THR_W'(25 << ANGLE_FRACTION_BITS);
  localparam logic [THR_W-1:0] ALARM_RESET = THR_W'(55 << ANGLE_FRACTION_BITS);
  localparam logic [THR_W-1:0] HUGE_RESET  = THR_W'(500 << ANGLE_FRACTION_BITS);

  typedef struct packed {
    logic [THR_W-1:0] turn;
    logic [THR_W-1:0] alarm;
    logic [THR_W-1:0] huge;
  } thresholds_t;

  // atan(2^-i) in degrees, rounded to the working angle scale.
  function automatic logic [Z_W-1:0] atan_step(input logic [IDX_W-1:0] i);
    logic [39:0] t;
    logic [39:0] r;
    case (i)
      5'd0:  t = 40'd188743680;
      5'd1:  t = 40'd111421900;
      5'd2:  t = 40'd58872272;
      5'd3:  t = 40'd29884485;
      5'd4:  t = 40'd15000234;
      5'd5:  t = 40'd7507429;
      5'd6:  t = 40'd3754631;
      5'd7:  t = 40'd1877430;
      5'd8:  t = 40'd938729;
      5'd9:  t = 40'd469366;
      5'd10: t = 40'd234683;
      5'd11: t = 40'd117342;
      5'd12: t = 40'd58671;
      5'd13: t = 40'd29335;
      5'd14: t = 40'd14668;
      5'd15: t = 40'd7334;
      5'd16: t = 40'd3667;
      5'd17: t = 40'd1833;
      5'd18: t = 40'd917;
      5'd19: t = 40'd458;
      5'd20: t = 40'd229;
      5'd21: t = 40'd115;
      5'd22: t = 40'd57;
      5'd23: t = 40'd29;
      default: t = 40'd0;
    endcase
    r = (t + 40'(ATAN_HALF)) >> ATAN_SHIFT;
    return Z_W'(r);
  endfunction

endpackage

### src/chet_div3.sv
// Bit-serial divider of an unsigned value by three, one quotient bit per cycle.
module chet_div3 (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [chet_pkg::DIV_W-1:0] dividend,
  output logic                      done,
  output logic [chet_pkg::DIV_W-1:0] quotient
);
  import chet_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] shreg;
  logic [1:0]       rem;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic [2:0]       trial;
  logic             fits;

  // Bring the next dividend bit down beside the remainder, most significant first.
  assign trial    = {rem, shreg[DIV_W-1]};
  assign fits     = (trial >= 3'd3);
  assign quotient = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        shreg <= dividend;
        rem   <= 2'd0;
      end else if (busy) begin
        shreg <= {shreg[DIV_W-2:0], fits};
        rem   <= fits ? 2'(trial - 3'd3) : trial[1:0];
        count <= count + 1'b1;
        if (count == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### src/chet_cordic.sv
// Iterative vectoring CORDIC that turns an x/y vector into a heading.
module chet_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [chet_pkg::MAG_W-1:0] ax,
  input  logic signed [chet_pkg::MAG_W-1:0] ay,
  output logic                              done,
  output logic [chet_pkg::HEAD_W-1:0]       heading
);
  import chet_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ITER  = 2'd1;
  localparam logic [1:0] PH_WRAP  = 2'd2;
  localparam logic [1:0] PH_ROUND = 2'd3;

  localparam logic signed [Z_W-1:0] Z_180 = Z_W'(180 * (2 ** WORK_BITS));
  localparam logic signed [Z_W-1:0] Z_360 = Z_W'(360 * (2 ** WORK_BITS));
  localparam logic signed [Z_W-1:0] Z_RND = Z_W'(1 << (GUARD_BITS - 1));
  localparam logic [HR_W-1:0]       HR_FULL = HR_W'(H_FULL);

  logic [1:0]              phase;
  logic [IDX_W-1:0]        iter;
  logic signed [XY_W-1:0]  x;
  logic signed [XY_W-1:0]  y;
  logic signed [Z_W-1:0]   z;
  logic signed [XY_W-1:0]  dx;
  logic signed [XY_W-1:0]  dy;
  logic signed [Z_W-1:0]   angle;
  logic                    y_pos;
  logic signed [XY_W-1:0]  x_init;
  logic signed [XY_W-1:0]  y_init;
  logic [Z_W-1:0]          z_rnd;
  logic [HR_W-1:0]         h_rnd;

  assign dx     = y >>> iter;
  assign dy     = x >>> iter;
  assign angle  = $signed(atan_step(iter));
  assign y_pos  = !y[XY_W-1] && (y != '0);
  assign x_init = {{(XY_W-MAG_W-8){ax[MAG_W-1]}}, ax, 8'd0};
  assign y_init = {{(XY_W-MAG_W-8){ay[MAG_W-1]}}, ay, 8'd0};
  assign z_rnd  = z + Z_RND;
  assign h_rnd  = z_rnd[Z_W-1:GUARD_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
      iter  <= '0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) begin
            // Vectors on an axis, and the zero vector, have exact headings.
            if (ay == '0) begin
              heading <= ax[MAG_W-1] ? HEAD_W'(H_HALF) : '0;
              done    <= 1'b1;
            end else if (ax == '0) begin
              heading <= ay[MAG_W-1] ? HEAD_W'(3 * H_QUARTER) : HEAD_W'(H_QUARTER);
              done    <= 1'b1;
            end else begin
              iter  <= '0;
              phase <= PH_ITER;
              if (ax[MAG_W-1]) begin
                x <= -x_init;
                y <= -y_init;
                z <= Z_180;
              end else begin
                x <= x_init;
                y <= y_init;
                z <= '0;
              end
            end
          end
        end
        PH_ITER: begin
          if (y_pos) begin
            x <= x + dx;
            y <= y - dy;
            z <= z + angle;
          end else begin
            x <= x - dx;
            y <= y + dy;
            z <= z - angle;
          end
          iter <= iter + 1'b1;
          if (iter == IDX_W'(ITER_N - 1)) begin
            phase <= PH_WRAP;
          end
        end
        PH_WRAP: begin
          if (z[Z_W-1]) begin
            z <= z + Z_360;
          end
          phase <= PH_ROUND;
        end
        PH_ROUND: begin
          heading <= (h_rnd >= HR_FULL) ? HEAD_W'(h_rnd - HR_FULL) : HEAD_W'(h_rnd);
          done    <= 1'b1;
          phase   <= PH_IDLE;
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

endmodule

### src/chet_apb.sv
// Threshold registers behind the APB-style configuration port.
module chet_apb (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [chet_pkg::PADDR_W-1:0]  paddr,
  input  logic [chet_pkg::PDATA_W-1:0]  pwdata,
  output logic [chet_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output chet_pkg::thresholds_t         thr
);
  import chet_pkg::*;

  logic       wr_en;
  logic [1:0] index;

  assign pready = 1'b1;
  assign index  = paddr[PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.turn  <= TURN_RESET;
      thr.alarm <= ALARM_RESET;
      thr.huge  <= HUGE_RESET;
    end else if (wr_en) begin
      case (index)
        REG_TURN:  thr.turn  <= pwdata[THR_W-1:0];
        REG_ALARM: thr.alarm <= pwdata[THR_W-1:0];
        REG_HUGE:  thr.huge  <= pwdata[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_TURN:  prdata = PDATA_W'(thr.turn);
      REG_ALARM: prdata = PDATA_W'(thr.alarm);
      REG_HUGE:  prdata = PDATA_W'(thr.huge);
      default:   prdata = '0;
    endcase
  end

endmodule

### src/compass_heading_error_tracker.sv
// Top level of the compass heading error tracker: grouping, sequencing and error tracking.
// The first two words of a group are only added in; the third holds the input off while
// the serial divides by three and the CORDIC run, and its result word is offered after the
// error and accumulation steps, or after a division of the heading sum when it completes
// a target. An axis mean skips the iterations; a third word without a result frees the input.
// Reset is synchronous and active high; it restores the threshold defaults and the idle state.
module compass_heading_error_tracker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata, from bit 0: mag_x[15:0], mag_y[31:16]
  input  logic [chet_pkg::IN_DATA_W-1:0]    s_tdata,
  // s_tuser: acquire[0]
  input  logic [0:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata, from bit 0: heading[15:0], target_heading[31:16], heading_error[47:32],
  // error_sum[79:48], steer_left[80], steer_right[81], alarm[82],
  // huge_positive[83], huge_negative[84], zero padding[87:85]
  output logic [chet_pkg::OUT_DATA_W-1:0]   m_tdata,
  // m_tuser: result_kind[0]
  output logic [0:0]                        m_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [chet_pkg::PADDR_W-1:0]      paddr,
  input  logic [chet_pkg::PDATA_W-1:0]      pwdata,
  output logic [chet_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);
  import chet_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_CORD = 3'd2;
  localparam logic [2:0] ST_ERR  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_TDIV = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  localparam logic signed [HEAD_W:0] E_HALF = (HEAD_W + 1)'(H_HALF);
  localparam logic signed [HEAD_W:0] E_FULL = (HEAD_W + 1)'(H_FULL);
  localparam logic signed [CUM_W:0]  C_MAX  = {2'b00, {(CUM_W-1){1'b1}}};
  localparam logic signed [CUM_W:0]  C_MIN  = {2'b11, {(CUM_W-1){1'b0}}};

  logic [2:0]              state;
  thresholds_t             thr;

  // Tracking state.
  logic [1:0]              group_count;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic                    need_target;
  logic [1:0]              acquire_count;
  logic [SUM_W-1:0]        heading_sum;
  logic [HEAD_W-1:0]       target;
  logic signed [CUM_W-1:0] cumulative;

  // Per-group working registers.
  logic                    sx_neg;
  logic                    sy_neg;
  logic [HEAD_W-1:0]       hd;
  logic signed [ERR_W-1:0] err;
  logic                    kind;

  // Input word unpacking.
  logic                    s_acc;
  logic signed [MAG_W-1:0] in_x;
  logic signed [MAG_W-1:0] in_y;
  logic                    in_acq;

  logic signed [SUM_W-1:0] sum_x_new;
  logic signed [SUM_W-1:0] sum_y_new;
  logic [1:0]              count_new;
  logic                    group_done;
  logic [DIV_W-1:0]        mag_x;
  logic [DIV_W-1:0]        mag_y;
  logic [SUM_W-1:0]        heading_sum_new;

  // Divider and CORDIC hookup.
  logic                    divx_start;
  logic                    divy_start;
  logic [DIV_W-1:0]        divx_dividend;
  logic                    divx_done;
  logic                    divy_done;
  logic [DIV_W-1:0]        divx_q;
  logic [DIV_W-1:0]        divy_q;
  logic                    cord_start;
  logic signed [MAG_W-1:0] avg_x;
  logic signed [MAG_W-1:0] avg_y;
  logic                    cord_done;
  logic [HEAD_W-1:0]       cord_heading;

  // Error and accumulation.
  logic signed [HEAD_W:0]  diff;
  logic signed [HEAD_W:0]  diff_wrapped;
  logic signed [CUM_W:0]   acc_sum;
  logic signed [CUM_W-1:0] acc_sat;

  // Flags on the cumulative error.
  logic signed [CUM_W:0]   cum_s;
  logic signed [CUM_W:0]   cum_mag;
  logic signed [CUM_W:0]   turn_s;
  logic signed [CUM_W:0]   alarm_s;
  logic signed [CUM_W:0]   huge_s;
  logic                    steer_left;
  logic                    steer_right;
  logic                    alarm;
  logic                    huge_positive;
  logic                    huge_negative;
  logic                    out_free;

  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign in_x     = s_tdata[MAG_W-1:0];
  assign in_y     = s_tdata[2*MAG_W-1:MAG_W];
  assign in_acq   = s_tuser[0];

  // An acquire word throws away the partial group before it is added in.
  assign sum_x_new  = (in_acq ? '0 : sum_x) + {{(SUM_W-MAG_W){in_x[MAG_W-1]}}, in_x};
  assign sum_y_new  = (in_acq ? '0 : sum_y) + {{(SUM_W-MAG_W){in_y[MAG_W-1]}}, in_y};
  assign count_new  = (in_acq ? 2'd0 : group_count) + 2'd1;
  assign group_done = s_acc && (count_new == 2'd3);

  // The average truncates toward zero, so the magnitude is divided and the sign put back.
  assign mag_x = sum_x_new[SUM_W-1] ? DIV_W'(-sum_x_new) : DIV_W'(sum_x_new);
  assign mag_y = sum_y_new[SUM_W-1] ? DIV_W'(-sum_y_new) : DIV_W'(sum_y_new);

  assign heading_sum_new = heading_sum + SUM_W'(cord_heading);

  // The x lane of the divider also forms the rounded mean of the three target headings.
  assign divy_start    = group_done;
  assign divx_start    = group_done ||
                         ((state == ST_CORD) && cord_done && need_target &&
                          (acquire_count == 2'd2));
  assign divx_dividend = (state == ST_IDLE) ? mag_x : DIV_W'(heading_sum_new + 1'b1);

  assign avg_x      = sx_neg ? MAG_W'(-divx_q[MAG_W-1:0]) : divx_q[MAG_W-1:0];
  assign avg_y      = sy_neg ? MAG_W'(-divy_q[MAG_W-1:0]) : divy_q[MAG_W-1:0];
  assign cord_start = (state == ST_DIV) && divx_done && divy_done;

  chet_div3 u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (divx_start),
    .dividend (divx_dividend),
    .done     (divx_done),
    .quotient (divx_q)
  );

  chet_div3 u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (divy_start),
    .dividend (mag_y),
    .done     (divy_done),
    .quotient (divy_q)
  );

  chet_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cord_start),
    .ax      (avg_x),
    .ay      (avg_y),
    .done    (cord_done),
    .heading (cord_heading)
  );

  chet_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr     (thr)
  );

  // Heading error, wrapped into plus or minus half a turn.
  always_comb begin
    diff = $signed({1'b0, hd}) - $signed({1'b0, target});
    if (diff > E_HALF) begin
      diff_wrapped = diff - E_FULL;
    end else if (diff < -E_HALF) begin
      diff_wrapped = diff + E_FULL;
    end else begin
      diff_wrapped = diff;
    end
  end

  // Saturating accumulation of the error.
  always_comb begin
    acc_sum = {cumulative[CUM_W-1], cumulative} +
              {{(CUM_W+1-ERR_W){err[ERR_W-1]}}, err};
    if (acc_sum > C_MAX) begin
      acc_sat = C_MAX[CUM_W-1:0];
    end else if (acc_sum < C_MIN) begin
      acc_sat = C_MIN[CUM_W-1:0];
    end else begin
      acc_sat = acc_sum[CUM_W-1:0];
    end
  end

  // Threshold comparisons are made one bit wider so that the negated thresholds fit.
  assign cum_s         = {cumulative[CUM_W-1], cumulative};
  assign cum_mag       = cum_s[CUM_W] ? -cum_s : cum_s;
  assign turn_s        = $signed({2'b00, thr.turn});
  assign alarm_s       = $signed({2'b00, thr.alarm});
  assign huge_s        = $signed({2'b00, thr.huge});
  assign steer_left    = (cum_s > turn_s);
  assign steer_right   = (cum_s < -turn_s);
  assign alarm         = (cum_mag >= alarm_s);
  assign huge_positive = (cum_s >= huge_s);
  assign huge_negative = (cum_s <= -huge_s);

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      group_count   <= 2'd0;
      sum_x         <= '0;
      sum_y         <= '0;
      need_target   <= 1'b1;
      acquire_count <= 2'd0;
      heading_sum   <= '0;
      target        <= '0;
      cumulative    <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      // A taken word is cleared unless a new one is loaded at the same edge.
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            if (in_acq) begin
              need_target   <= 1'b1;
              acquire_count <= 2'd0;
              heading_sum   <= '0;
            end
            if (group_done) begin
              group_count <= 2'd0;
              sum_x       <= '0;
              sum_y       <= '0;
              sx_neg      <= sum_x_new[SUM_W-1];
              sy_neg      <= sum_y_new[SUM_W-1];
              state       <= ST_DIV;
            end else begin
              group_count <= count_new;
              sum_x       <= sum_x_new;
              sum_y       <= sum_y_new;
            end
          end
        end
        ST_DIV: begin
          if (divx_done && divy_done) begin
            state <= ST_CORD;
          end
        end
        ST_CORD: begin
          if (cord_done) begin
            hd <= cord_heading;
            if (need_target) begin
              if (acquire_count == 2'd2) begin
                acquire_count <= 2'd0;
                heading_sum   <= '0;
                state         <= ST_TDIV;
              end else begin
                acquire_count <= acquire_count + 2'd1;
                heading_sum   <= heading_sum_new;
                state         <= ST_IDLE;
              end
            end else begin
              state <= ST_ERR;
            end
          end
        end
        ST_ERR: begin
          err   <= diff_wrapped[ERR_W-1:0];
          kind  <= 1'b0;
          state <= ST_ACC;
        end
        ST_ACC: begin
          cumulative <= acc_sat;
          state      <= ST_EMIT;
        end
        ST_TDIV: begin
          if (divx_done) begin
            target      <= divx_q[HEAD_W-1:0];
            cumulative  <= '0;
            need_target <= 1'b0;
            err         <= '0;
            kind        <= 1'b1;
            state       <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // The result waits here only while the previous word is still unclaimed.
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tuser[0] <= kind;
            m_tdata    <= {3'b000, huge_negative, huge_positive, alarm, steer_right,
                           steer_left, cumulative, err, target, hd};
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### src/chet_checker.sv
// Port-level checker for the compass heading error tracker, bound to the top level.
module chet_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [chet_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [0:0]                      m_tuser
);
  import chet_pkg::*;

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // A new target starts with no error and a cleared cumulative error.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata[47:32] == 16'd0) && (m_tdata[79:48] == 32'd0))
    else $error("acquisition result carries a non-zero error");

  // Steering left and right exclude each other.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[80] && m_tdata[81]))
    else $error("steer left and steer right both set");

  // Heading and target stay below a full turn.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] < 16'(H_FULL)) && (m_tdata[31:16] < 16'(H_FULL)))
    else $error("heading or target beyond a full turn");

endmodule

bind compass_heading_error_tracker chet_checker u_chet_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### tb/tb_compass_heading_error_tracker.sv
// Self-checking testbench for the compass heading error tracker, with stimulus and scoreboard.
`timescale 1ns / 100ps

module tb_compass_heading_error_tracker;

  // The predictor keeps its own angle scale, taken from the block's resolution settings.
  localparam int     FRAC      = chet_pkg::ANGLE_FRACTION_BITS;
  localparam int     ITERS     = chet_pkg::CORDIC_ITERATIONS;
  localparam int     GUARD     = 12;
  localparam int     WORK      = FRAC + GUARD;
  localparam int     TAB_FRAC  = 22;
  localparam int     TAB_LEN   = 24;
  localparam longint ANG_QUART = 64'sd90 << FRAC;
  localparam longint ANG_HALF  = 64'sd180 << FRAC;
  localparam longint ANG_FULL  = 64'sd360 << FRAC;

  // The spare register slot, which the block must ignore.
  localparam logic [1:0] REG_SPARE = 2'd3;

  // Run shape. The settling pause and the watchdog leave a wide margin over the slowest
  // correct run of a third word or of a completed target.
  localparam int PHASES        = 6;
  localparam int WORDS_PER_RUN = 170;
  localparam int SETTLE_CYCLES = 150;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int LONG_HOLD     = 400;
  localparam int QUIET_LIMIT   = 3000;
  localparam int MAX_PRINTS    = 40;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        acq;
  } mag_sample_t;

  typedef struct {
    logic        kind;
    logic [15:0] heading;
    logic [15:0] target;
    logic [15:0] err;
    logic [31:0] cum;
    logic        steer_left;
    logic        steer_right;
    logic        alarm;
    logic        huge_pos;
    logic        huge_neg;
  } nav_result_t;

  logic                              clk     = 1'b0;
  logic                              rst     = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [chet_pkg::IN_DATA_W-1:0]    s_tdata = '0;
  logic [0:0]                        s_tuser = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [chet_pkg::OUT_DATA_W-1:0]   m_tdata;
  logic [0:0]                        m_tuser;
  logic                              psel    = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite  = 1'b0;
  logic [chet_pkg::PADDR_W-1:0]      paddr   = '0;
  logic [chet_pkg::PDATA_W-1:0]      pwdata  = '0;
  logic [chet_pkg::PDATA_W-1:0]      prdata;
  logic                              pready;

  compass_heading_error_tracker u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Words waiting to be sent, and the results that the predictor says must follow.
  mag_sample_t sample_queue [$];
  nav_result_t nav_expected [$];
  mag_sample_t next_sample;
  nav_result_t want;

  // Predictor copy of the block's state and thresholds.
  int          grp_count;
  int          sum_x;
  int          sum_y;
  bit          need_target;
  int          acq_count;
  int unsigned heading_sum;
  int unsigned target_hd;
  int          cum_err;
  logic [30:0] turn_thr;
  logic [30:0] alarm_thr;
  logic [30:0] huge_thr;

  // Run control shared between the stimulus thread and the two bus processes.
  int idle_pct      = 15;
  int holds_wanted  = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int stall_left    = 0;
  int gap_left      = 0;

  // Bookkeeping for the closing summary.
  int mismatches    = 0;
  int words_sent    = 0;
  int tracks_seen   = 0;
  int targets_seen  = 0;
  int settings_used = 1;
  int hits_left     = 0;
  int hits_right    = 0;
  int hits_alarm    = 0;
  int hits_huge_pos = 0;
  int hits_huge_neg = 0;

  task automatic flag_mismatch(input string what, input longint got, input longint exp_val);
    if (mismatches < MAX_PRINTS)
      $display("%0t: mismatch on %s: got 'h%0h, expected 'h%0h", $time, what, got, exp_val);
    mismatches++;
  endtask

  // atan(2^-i) in degrees with 22 fraction bits, brought to the working angle scale.
  function automatic longint angle_step(input int i);
    longint t;
    int     s;
    case (i)
      0:  t = 188743680;
      1:  t = 111421900;
      2:  t = 58872272;
      3:  t = 29884485;
      4:  t = 15000234;
      5:  t = 7507429;
      6:  t = 3754631;
      7:  t = 1877430;
      8:  t = 938729;
      9:  t = 469366;
      10: t = 234683;
      11: t = 117342;
      12: t = 58671;
      13: t = 29335;
      14: t = 14668;
      15: t = 7334;
      16: t = 3667;
      17: t = 1833;
      18: t = 917;
      19: t = 458;
      20: t = 229;
      21: t = 115;
      22: t = 57;
      23: t = 29;
      default: t = 0;
    endcase
    s = TAB_FRAC - WORK;
    if (s > 0)
      return (t + (64'sd1 <<< (s - 1))) >>> s;
    if (s < 0)
      return t * (64'sd1 <<< (-s));
    return t;
  endfunction

  // Vectoring CORDIC: heading of the averaged vector in output units, 0 up to a full circle.
  function automatic int unsigned cordic_heading(input int ax, input int ay);
    longint x;
    longint y;
    longint z;
    longint h;
    longint dx;
    longint dy;
    longint a;
    int     i;
    if (ay == 0)
      return (ax < 0) ? int'(2 * ANG_QUART) : 0;
    if (ax == 0)
      return (ay > 0) ? int'(ANG_QUART) : int'(3 * ANG_QUART);
    x = longint'(ax) * 256;
    y = longint'(ay) * 256;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 64'sd180 <<< WORK;
    end
    for (i = 0; i < ITERS && i < TAB_LEN; i++) begin
      // Arithmetic shifts on signed values are floor shifts.
      dx = y >>> i;
      dy = x >>> i;
      a  = angle_step(i);
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + a;
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - a;
      end
    end
    if (z < 0)
      z = z + (64'sd360 <<< WORK);
    h = (z + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
    if (h >= ANG_FULL)
      h = h - ANG_FULL;
    return int'(h);
  endfunction

  function automatic void push_result(input logic kind, input int unsigned hd, input longint err);
    nav_result_t r;
    longint      c;
    c = longint'(cum_err);
    r.kind        = kind;
    r.heading     = hd[15:0];
    r.target      = target_hd[15:0];
    r.err         = err[15:0];
    r.cum         = cum_err;
    r.steer_left  = c > longint'(turn_thr);
    r.steer_right = c < -longint'(turn_thr);
    r.alarm       = ((c < 0) ? -c : c) >= longint'(alarm_thr);
    r.huge_pos    = c >= longint'(huge_thr);
    r.huge_neg    = c <= -longint'(huge_thr);
    nav_expected.push_back(r);
  endfunction

  // Advances the predictor by one accepted word and queues any result it causes.
  task automatic track_sample(input logic [15:0] raw_x, input logic [15:0] raw_y,
                              input logic acq);
    int unsigned hd;
    longint      err;
    longint      total;
    if (acq) begin
      grp_count   = 0;
      sum_x       = 0;
      sum_y       = 0;
      need_target = 1'b1;
      acq_count   = 0;
      heading_sum = 0;
    end
    sum_x = sum_x + int'($signed(raw_x));
    sum_y = sum_y + int'($signed(raw_y));
    grp_count++;
    if (grp_count < 3)
      return;
    // Integer division truncates toward zero, as the block's average does.
    hd        = cordic_heading(sum_x / 3, sum_y / 3);
    grp_count = 0;
    sum_x     = 0;
    sum_y     = 0;
    if (need_target) begin
      heading_sum = heading_sum + hd;
      acq_count++;
      if (acq_count < 3)
        return;
      target_hd   = (heading_sum + 1) / 3;
      cum_err     = 0;
      need_target = 1'b0;
      acq_count   = 0;
      heading_sum = 0;
      push_result(1'b1, hd, 0);
      return;
    end
    err = longint'(hd) - longint'(target_hd);
    if (err > ANG_HALF)
      err = err - ANG_FULL;
    if (err < -ANG_HALF)
      err = err + ANG_FULL;
    total = longint'(cum_err) + err;
    if (total > 64'sd2147483647)
      total = 64'sd2147483647;
    if (total < -64'sd2147483648)
      total = -64'sd2147483648;
    cum_err = int'(total);
    push_result(1'b0, hd, err);
  endtask

  task automatic compare_result(input nav_result_t exp_r);
    if (m_tuser[0] !== exp_r.kind)
      flag_mismatch("result_kind", m_tuser[0], exp_r.kind);
    if (m_tdata[15:0] !== exp_r.heading)
      flag_mismatch("heading", m_tdata[15:0], exp_r.heading);
    if (m_tdata[31:16] !== exp_r.target)
      flag_mismatch("target_heading", m_tdata[31:16], exp_r.target);
    if (m_tdata[47:32] !== exp_r.err)
      flag_mismatch("heading_error", m_tdata[47:32], exp_r.err);
    if (m_tdata[79:48] !== exp_r.cum)
      flag_mismatch("error_sum", m_tdata[79:48], exp_r.cum);
    if (m_tdata[80] !== exp_r.steer_left)
      flag_mismatch("steer_left", m_tdata[80], exp_r.steer_left);
    if (m_tdata[81] !== exp_r.steer_right)
      flag_mismatch("steer_right", m_tdata[81], exp_r.steer_right);
    if (m_tdata[82] !== exp_r.alarm)
      flag_mismatch("alarm", m_tdata[82], exp_r.alarm);
    if (m_tdata[83] !== exp_r.huge_pos)
      flag_mismatch("huge_positive", m_tdata[83], exp_r.huge_pos);
    if (m_tdata[84] !== exp_r.huge_neg)
      flag_mismatch("huge_negative", m_tdata[84], exp_r.huge_neg);
    if (exp_r.kind)
      targets_seen++;
    else
      tracks_seen++;
    hits_left     += exp_r.steer_left;
    hits_right    += exp_r.steer_right;
    hits_alarm    += exp_r.alarm;
    hits_huge_pos += exp_r.huge_pos;
    hits_huge_neg += exp_r.huge_neg;
  endtask

  // Sender. A word on offer stays put until it is taken; only then may the next one or a
  // gap follow. Gaps start at random, as often as the idle percentage asks.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (sample_queue.size() != 0 && idle_pct > 0 &&
                   $urandom_range(0, 99) < idle_pct) begin
        gap_left <= $urandom_range(0, 6);
        s_tvalid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        next_sample = sample_queue.pop_front();
        s_tdata  <= {next_sample.y, next_sample.x};
        s_tuser  <= next_sample.acq;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver. A long hold-off, when asked for, is counted here so that the sender keeps
  // offering words meanwhile and the block backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (holds_served != holds_wanted) begin
      holds_served <= holds_served + 1;
      hold_left    <= LONG_HOLD;
      m_tready     <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 6);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: results are checked against the oldest expectation, and every accepted input
  // word is run through the predictor. A result can never belong to a word taken at the
  // same edge, so the order of the two steps does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (nav_expected.size() == 0) begin
          flag_mismatch("result with nothing expected", m_tdata[15:0], 0);
        end else begin
          want = nav_expected.pop_front();
          compare_result(want);
        end
      end
      if (s_tvalid && s_tready) begin
        track_sample(s_tdata[15:0], s_tdata[31:16], s_tuser[0]);
        words_sent++;
      end
    end
  end

  // Watchdog: the run is abandoned after a long stretch in which no word moves either way.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic push_sample(input int x, input int y, input bit acq);
    mag_sample_t smp;
    smp.x   = x[15:0];
    smp.y   = y[15:0];
    smp.acq = acq;
    sample_queue.push_back(smp);
  endtask

  // A raw reading: mostly full range, with a fair share of small, extreme and zero values.
  function automatic int random_reading();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)
      return int'($urandom_range(0, 65535)) - 32768;
    if (pick < 75)
      return int'($urandom_range(0, 1024)) - 512;
    if (pick < 90) begin
      case ($urandom_range(0, 5))
        0:       return -32768;
        1:       return -32767;
        2:       return -1;
        3:       return 1;
        4:       return 32767;
        default: return 0;
      endcase
    end
    return 0;
  endfunction

  function automatic int nudge(input int v, input int amt);
    int r;
    r = v + int'($urandom_range(0, 2 * amt)) - amt;
    if (r > 32767)
      r = 32767;
    if (r < -32768)
      r = -32768;
    return r;
  endfunction

  // Mostly whole sessions: an acquire word opens three acquisition groups, after which a
  // run of tracking groups follows, most of them pointing one way so that the error builds
  // up and the thresholds are crossed. Now and then an acquire lands in mid-group, and a
  // small part of the stream is plain noise with acquires scattered through it.
  task automatic queue_random_stretch(input int count);
    int sent;
    int groups;
    int g;
    int k;
    int n;
    int bx;
    int by;
    int cx;
    int cy;
    int vx;
    int vy;
    int jit;
    int spread;
    int choice;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 85) begin
        bx     = random_reading();
        by     = random_reading();
        cx     = random_reading();
        cy     = random_reading();
        spread = $urandom_range(0, 1) ? 40 : 2000;
        for (k = 0; k < 9; k++)
          push_sample(nudge(bx, spread), nudge(by, spread), k == 0);
        sent   = sent + 9;
        groups = $urandom_range(2, 12);
        for (g = 0; g < groups; g++) begin
          choice = $urandom_range(0, 99);
          jit    = spread;
          if (choice < 60) begin
            vx = cx;
            vy = cy;
          end else if (choice < 80) begin
            vx = random_reading();
            vy = random_reading();
          end else if (choice < 90) begin
            // A vector on an axis must stay exactly on it.
            jit = 0;
            if ($urandom_range(0, 1)) begin
              vx = random_reading();
              vy = 0;
            end else begin
              vx = 0;
              vy = random_reading();
            end
          end else begin
            vx = bx;
            vy = by;
          end
          for (k = 0; k < 3; k++)
            push_sample(nudge(vx, jit), nudge(vy, jit), $urandom_range(0, 99) < 2);
          sent = sent + 3;
        end
      end else begin
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++)
          push_sample(random_reading(), random_reading(), $urandom_range(0, 4) == 0);
        sent = sent + n;
      end
    end
  endtask

  // A register write: a setup phase, then an access phase, after which the write has taken.
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Only 31 bits are kept; the spare slot changes nothing.
    if (idx == chet_pkg::REG_TURN)
      turn_thr = value[30:0];
    else if (idx == chet_pkg::REG_ALARM)
      alarm_thr = value[30:0];
    else if (idx == chet_pkg::REG_HUGE)
      huge_thr = value[30:0];
  endtask

  task automatic program_thresholds(input logic [31:0] turn, input logic [31:0] alarm,
                                    input logic [31:0] huge_v);
    apb_write(chet_pkg::REG_TURN, turn);
    apb_write(chet_pkg::REG_ALARM, alarm);
    apb_write(chet_pkg::REG_HUGE, huge_v);
    settings_used++;
  endtask

  // Waits until every queued word has gone and every expected result has come back, then
  // gives the block time to finish a third word that produced no result.
  task automatic settle_block();
    int n;
    n = 0;
    while ((sample_queue.size() != 0 || s_tvalid || nav_expected.size() != 0) &&
           n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int          phase;
    nav_result_t left_over;

    grp_count   = 0;
    sum_x       = 0;
    sum_y       = 0;
    need_target = 1'b1;
    acq_count   = 0;
    heading_sum = 0;
    target_hd   = 0;
    cum_err     = 0;
    turn_thr    = 31'(25 << FRAC);
    alarm_thr   = 31'(55 << FRAC);
    huge_thr    = 31'(500 << FRAC);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset thresholds. Acquisition on the three axis headings
    // 0, 90 and 180 degrees, using the extreme readings.
    push_sample(32767, 0, 1'b1);
    push_sample(32767, 0, 1'b0);
    push_sample(32767, 0, 1'b0);
    push_sample(0, 32767, 1'b0);
    push_sample(0, 32767, 1'b0);
    push_sample(0, 32767, 1'b0);
    push_sample(-32768, 0, 1'b0);
    push_sample(-32768, 0, 1'b0);
    push_sample(-32768, 0, 1'b0);
    // The zero vector, then due south, which sits exactly half a circle from the target.
    push_sample(0, 0, 1'b0);
    push_sample(0, 0, 1'b0);
    push_sample(0, 0, 1'b0);
    push_sample(0, -32768, 1'b0);
    push_sample(0, -32768, 1'b0);
    push_sample(0, -32768, 1'b0);
    // A partial group dropped by an acquire, then a second acquire in mid-acquisition,
    // which restarts it with that word.
    push_sample(12345, -23456, 1'b0);
    push_sample(1, -1, 1'b0);
    push_sample(7, -9, 1'b1);
    push_sample(7, -9, 1'b0);
    push_sample(-5, 3, 1'b1);
    repeat (8) push_sample(-5, 3, 1'b0);
    settle_block();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: program_thresholds(32'd0, 32'd0, 32'd0);
        1: begin
          program_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
          apb_write(REG_SPARE, $urandom);
        end
        3: program_thresholds(32'd3200, 32'd7040, 32'd64000);
        default: program_thresholds(
                   {1'($urandom_range(0, 1)), 31'($urandom_range(0, 8000))},
                   {1'($urandom_range(0, 1)), 31'($urandom_range(0, 16000))},
                   {1'($urandom_range(0, 1)), 31'($urandom_range(0, 120000))});
      endcase
      // Idling varies from phase to phase; the fourth phase runs flat out and so does the
      // last one.
      case (phase)
        0:       idle_pct = 20;
        1:       idle_pct = 35;
        2:       idle_pct = 10;
        3:       idle_pct = 0;
        4:       idle_pct = 25;
        default: idle_pct = 0;
      endcase
      if (phase == 2)
        holds_wanted++;
      queue_random_stretch(WORDS_PER_RUN);
      settle_block();
    end

    while (nav_expected.size() != 0) begin
      left_over = nav_expected.pop_front();
      flag_mismatch("result never delivered", 0, left_over.heading);
    end

    $display("Sent %0d words under %0d threshold settings; checked %0d tracking and %0d %s",
             words_sent, settings_used, tracks_seen, targets_seen, "target results.");
    $display("Flags seen set: steer left %0d, steer right %0d, alarm %0d, huge +%0d, huge -%0d.",
             hits_left, hits_right, hits_alarm, hits_huge_pos, hits_huge_neg);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
